// ----- hdl/page_frame_allocator_with_victim_assert.svh -----
// assertion macros for the checker file
`ifndef PAGE_FRAME_ALLOCATOR_WITH_VICTIM_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_WITH_VICTIM_ASSERT_SVH

// plain property checked on every clock outside reset
`define PFA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// implication checked on every clock outside reset
`define PFA_ASSERT_IMP(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);

`endif

// ----- hdl/pfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pfa_pkg
// Types and codes of the page frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

    typedef struct packed {
        logic [2:0]  mode;
        logic [9:0]  frame;
        logic [2:0]  frame_kind;
        logic [19:0] vpage;
        logic [15:0] owner_tag;
        logic [31:0] age;
    } pfa_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  frame_out;
        logic        evicted;
        logic [19:0] evicted_vpage;
        logic [15:0] evicted_owner;
        logic [10:0] free_count;
    } pfa_out_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       alloc;
        logic       pageable;
        logic       on_list;
    } pfa_flags_t;

    typedef struct packed {
        logic flag;
        logic age;
        logic pv;
        logic fifo;
    } pfa_mem_we_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_LOOK, ST_EXEC, ST_POP, ST_POPW,
        ST_SCAN, ST_VICT, ST_VICTW, ST_FIN
    } pfa_state_t;

    localparam logic [2:0] MODE_ADD      = 3'd0;
    localparam logic [2:0] MODE_ALLOC    = 3'd1;
    localparam logic [2:0] MODE_ALLOC_PG = 3'd2;
    localparam logic [2:0] MODE_FREE     = 3'd3;
    localparam logic [2:0] MODE_SET_AGE  = 3'd4;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_FREE   = 2'd1;
    localparam logic [1:0] STATUS_NOT_ALLOC = 2'd2;
    localparam logic [1:0] STATUS_NO_VICTIM = 2'd3;

    localparam logic [2:0] KIND_AVAILABLE = 3'd1;
    localparam logic [2:0] KIND_ALLOCATED = 3'd4;

endpackage

`default_nettype wire

// ----- hdl/pfa_store.sv -----
// ----------------------------------------------------------------------------
// pfa_store
// Per-frame memories (flags, age, virtual page and owner) and the free fifo.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_store
    import pfa_pkg::*;
#(
    parameter int FRAMES = 1024,
    parameter int IW     = 10
) (
    input  wire logic        aclk,
    input  wire pfa_mem_we_t we,
    input  wire logic [IW-1:0] flag_addr,
    input  wire pfa_flags_t  flag_wdata,
    output pfa_flags_t       flag_rdata,
    input  wire logic [IW-1:0] age_addr,
    input  wire logic [31:0] age_wdata,
    output logic [31:0]      age_rdata,
    input  wire logic [IW-1:0] pv_addr,
    input  wire logic [19:0] vpage_wdata,
    input  wire logic [15:0] owner_wdata,
    output logic [19:0]      vpage_rdata,
    output logic [15:0]      owner_rdata,
    input  wire logic [IW-1:0] fifo_raddr,
    input  wire logic [IW-1:0] fifo_waddr,
    input  wire logic [IW-1:0] fifo_wdata,
    output logic [IW-1:0]    fifo_rdata
);

    pfa_flags_t    flag_mem  [FRAMES];
    logic [31:0]   age_mem   [FRAMES];
    logic [19:0]   vpage_mem [FRAMES];
    logic [15:0]   owner_mem [FRAMES];
    logic [IW-1:0] fifo_mem  [FRAMES];

    always_ff @(posedge aclk) begin
        if (we.flag) begin
            flag_mem[flag_addr] <= flag_wdata;
        end
        flag_rdata <= flag_mem[flag_addr];
    end

    always_ff @(posedge aclk) begin
        if (we.age) begin
            age_mem[age_addr] <= age_wdata;
        end
        age_rdata <= age_mem[age_addr];
    end

    always_ff @(posedge aclk) begin
        if (we.pv) begin
            vpage_mem[pv_addr] <= vpage_wdata;
            owner_mem[pv_addr] <= owner_wdata;
        end
        vpage_rdata <= vpage_mem[pv_addr];
        owner_rdata <= owner_mem[pv_addr];
    end

    always_ff @(posedge aclk) begin
        if (we.fifo) begin
            fifo_mem[fifo_waddr] <= fifo_wdata;
        end
        fifo_rdata <= fifo_mem[fifo_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/pfa_victim.sv -----
// ----------------------------------------------------------------------------
// pfa_victim
// Age comparator that keeps the oldest allocated pageable frame.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_victim
    import pfa_pkg::*;
#(
    parameter int IW = 10
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic          cand_vld,
    input  wire logic [IW-1:0] cand_idx,
    input  wire pfa_flags_t    cand_flags,
    input  wire logic [31:0]   cand_age,
    output logic               found,
    output logic [IW-1:0]      best_idx
);

    logic          found_reg, found_next;
    logic [IW-1:0] best_idx_reg, best_idx_next;
    logic [31:0]   best_age_reg, best_age_next;
    logic          take;

    // strict less keeps the lowest index on ties
    assign take = cand_vld && cand_flags.alloc && cand_flags.pageable &&
                  (!found_reg || (cand_age < best_age_reg));

    always_comb begin
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_age_next = best_age_reg;
        if (start) begin
            found_next = 1'b0;
        end else if (take) begin
            found_next    = 1'b1;
            best_idx_next = cand_idx;
            best_age_next = cand_age;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
        best_idx_reg <= best_idx_next;
        best_age_reg <= best_age_next;
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;

endmodule

`default_nettype wire

// ----- hdl/page_frame_allocator_with_victim.sv -----
// ----------------------------------------------------------------------------
// page_frame_allocator_with_victim
// Physical frame manager with a fifo free list and oldest-frame victim search.
// ----------------------------------------------------------------------------
// After reset the block sweeps its flag memory, clearing every frame, and holds
// s_ready low meanwhile. One item is handled at a time. Add, free, set age,
// allocate with an empty list and unknown modes pass a lookup and an execute
// state and then the finish state, which loads the result register and raises
// m_valid. Allocate and allocate pageable with a non-empty list add a pop state
// and a write-back state, and allocate pageable with an empty list scans every
// frame through the single flag/age read port and one age comparator, then adds
// a read and a write state when a victim is found. A waiting result on m_ is held
// until taken; the next item may be accepted meanwhile, and its own result
// waits in the finish state until the previous one is gone.
`default_nettype none

module page_frame_allocator_with_victim
    import pfa_pkg::*;
#(
    parameter int FRAMES = 1024
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire pfa_in_t s_item,
    output logic         m_valid,
    input  wire logic    m_ready,
    output pfa_out_t     m_item
);

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);

    pfa_state_t    state_reg, state_next;
    pfa_in_t       item_reg, item_next;
    pfa_out_t      res_reg, res_next;
    pfa_out_t      mout_reg, mout_next;
    logic          m_valid_reg, m_valid_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] g_reg, g_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;

    pfa_mem_we_t   we;
    logic [IW-1:0] flag_addr, age_addr, pv_addr;
    pfa_flags_t    flag_wdata, flag_rdata;
    logic [31:0]   age_wdata, age_rdata;
    logic [19:0]   vpage_wdata, vpage_rdata;
    logic [15:0]   owner_wdata, owner_rdata;
    logic [IW-1:0] fifo_wdata, fifo_rdata;
    logic          vic_start, vic_found;
    logic [IW-1:0] vic_idx;

    logic          in_range;
    logic [IW-1:0] f_idx;
    logic          accept;
    logic          out_free;
    logic          scan_done;

    assign in_range  = 32'(item_reg.frame) < FRAMES;
    assign f_idx     = IW'(item_reg.frame);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign scan_done = (cnt_reg == CW'(FRAMES)) && !cmp_vld_reg;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
        logic [IW-1:0] r;
        r = (p == IW'(FRAMES - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    pfa_store #(.FRAMES(FRAMES), .IW(IW)) u_store (
        .aclk        (aclk),
        .we          (we),
        .flag_addr   (flag_addr),
        .flag_wdata  (flag_wdata),
        .flag_rdata  (flag_rdata),
        .age_addr    (age_addr),
        .age_wdata   (age_wdata),
        .age_rdata   (age_rdata),
        .pv_addr     (pv_addr),
        .vpage_wdata (vpage_wdata),
        .owner_wdata (owner_wdata),
        .vpage_rdata (vpage_rdata),
        .owner_rdata (owner_rdata),
        .fifo_raddr  (head_reg),
        .fifo_waddr  (tail_reg),
        .fifo_wdata  (fifo_wdata),
        .fifo_rdata  (fifo_rdata)
    );

    pfa_victim #(.IW(IW)) u_victim (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (vic_start),
        .cand_vld   (cmp_vld_reg),
        .cand_idx   (cmp_idx_reg),
        .cand_flags (flag_rdata),
        .cand_age   (age_rdata),
        .found      (vic_found),
        .best_idx   (vic_idx)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (cnt_reg == CW'(FRAMES - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (accept) state_next = ST_LOOK;
            ST_LOOK:  state_next = ST_EXEC;
            ST_EXEC: begin
                if ((item_reg.mode == MODE_ALLOC || item_reg.mode == MODE_ALLOC_PG)
                    && total_reg != '0) begin
                    state_next = ST_POP;
                end else if (item_reg.mode == MODE_ALLOC_PG) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_POP:   state_next = ST_POPW;
            ST_POPW:  state_next = ST_FIN;
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = vic_found ? ST_VICT : ST_FIN;
                end
            end
            ST_VICT:  state_next = ST_VICTW;
            ST_VICTW: state_next = ST_FIN;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        item_next    = item_reg;
        res_next     = res_reg;
        mout_next    = mout_reg;
        m_valid_next = m_valid_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        total_next   = total_reg;
        cnt_next     = cnt_reg;
        g_next       = g_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        we           = '0;
        flag_addr    = f_idx;
        age_addr     = f_idx;
        pv_addr      = f_idx;
        flag_wdata   = flag_rdata;
        age_wdata    = '0;
        vpage_wdata  = '0;
        owner_wdata  = '0;
        fifo_wdata   = f_idx;
        vic_start    = 1'b0;
        s_ready      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                we.flag    = 1'b1;
                flag_addr  = cnt_reg[IW-1:0];
                flag_wdata = '0;
                cnt_next   = cnt_reg + 1'b1;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    item_next = s_item;
                    res_next  = '0;
                end
            end
            ST_LOOK: ;
            ST_EXEC: begin
                unique case (item_reg.mode) inside
                    MODE_ADD: begin
                        if (in_range && !flag_rdata.on_list) begin
                            we.flag             = 1'b1;
                            we.age              = 1'b1;
                            we.pv               = 1'b1;
                            flag_wdata.kind     = item_reg.frame_kind;
                            flag_wdata.alloc    = item_reg.frame_kind == KIND_ALLOCATED;
                            flag_wdata.pageable = 1'b0;
                            flag_wdata.on_list  = item_reg.frame_kind == KIND_AVAILABLE;
                            if (item_reg.frame_kind == KIND_AVAILABLE) begin
                                we.fifo    = 1'b1;
                                tail_next  = wrap_inc(tail_reg);
                                total_next = total_reg + 1'b1;
                            end
                        end
                    end
                    MODE_ALLOC, MODE_ALLOC_PG: begin
                        if (total_reg != '0) begin
                            g_next = fifo_rdata;
                        end else if (item_reg.mode == MODE_ALLOC) begin
                            res_next.status = STATUS_NO_FREE;
                        end else begin
                            vic_start = 1'b1;
                            cnt_next  = '0;
                        end
                    end
                    MODE_FREE: begin
                        if (!in_range || !flag_rdata.alloc) begin
                            res_next.status = STATUS_NOT_ALLOC;
                        end else begin
                            we.flag             = 1'b1;
                            we.fifo             = 1'b1;
                            flag_wdata.alloc    = 1'b0;
                            flag_wdata.pageable = 1'b0;
                            flag_wdata.on_list  = 1'b1;
                            tail_next           = wrap_inc(tail_reg);
                            total_next          = total_reg + 1'b1;
                        end
                    end
                    MODE_SET_AGE: begin
                        if (in_range) begin
                            we.age    = 1'b1;
                            age_wdata = item_reg.age;
                        end
                    end
                    default: ;
                endcase
            end
            ST_POP: begin
                flag_addr = g_reg;
            end
            ST_POPW: begin
                flag_addr          = g_reg;
                pv_addr            = g_reg;
                we.flag            = 1'b1;
                flag_wdata.alloc   = 1'b1;
                flag_wdata.on_list = 1'b0;
                if (item_reg.mode == MODE_ALLOC_PG) begin
                    flag_wdata.pageable = 1'b1;
                    we.pv               = 1'b1;
                    vpage_wdata         = item_reg.vpage;
                    owner_wdata         = item_reg.owner_tag;
                end
                head_next          = wrap_inc(head_reg);
                total_next         = total_reg - 1'b1;
                res_next.frame_out = 10'(g_reg);
            end
            ST_SCAN: begin
                flag_addr = cnt_reg[IW-1:0];
                age_addr  = cnt_reg[IW-1:0];
                if (cnt_reg != CW'(FRAMES)) begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = cnt_reg[IW-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
                if (scan_done && !vic_found) begin
                    res_next.status = STATUS_NO_VICTIM;
                end
            end
            ST_VICT: begin
                pv_addr = vic_idx;
            end
            ST_VICTW: begin
                pv_addr                = vic_idx;
                we.pv                  = 1'b1;
                vpage_wdata            = item_reg.vpage;
                owner_wdata            = item_reg.owner_tag;
                res_next.evicted       = 1'b1;
                res_next.evicted_vpage = vpage_rdata;
                res_next.evicted_owner = owner_rdata;
                res_next.frame_out     = 10'(vic_idx);
            end
            ST_FIN: begin
                if (out_free) begin
                    mout_next            = res_reg;
                    mout_next.free_count = 11'(total_reg);
                    m_valid_next         = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            total_reg   <= '0;
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            total_reg   <= total_next;
            cnt_reg     <= cnt_next;
            cmp_vld_reg <= cmp_vld_next;
        end
        item_reg    <= item_next;
        res_reg     <= res_next;
        mout_reg    <= mout_next;
        g_reg       <= g_next;
        cmp_idx_reg <= cmp_idx_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = mout_reg;

endmodule

`default_nettype wire

// ----- hdl/pfa_checker.sv -----
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks of the page frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "page_frame_allocator_with_victim_assert.svh"

module pfa_checker
    import pfa_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire pfa_in_t  s_item,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire pfa_out_t m_item
);

    logic s_wait;
    logic alloc_fail;
    logic no_grant;
    logic list_empty;
    logic evicting;
    logic evict_ok;

    assign s_wait     = s_valid && !s_ready;
    assign alloc_fail = m_valid && (m_item.status == STATUS_NO_FREE ||
                                    m_item.status == STATUS_NO_VICTIM);
    assign no_grant   = (m_item.frame_out == '0) && !m_item.evicted;
    assign list_empty = m_item.free_count == '0;
    assign evicting   = m_valid && m_item.evicted;
    assign evict_ok   = (m_item.status == STATUS_OK) && list_empty;

    // a waiting input item stays put
    `PFA_ASSERT(a_in_hold, aclk, aresetn, s_wait |=> s_valid && $stable(s_item), "input changed")

    // a result waits until taken
    `PFA_ASSERT_IMP(a_out_hold, aclk, aresetn, m_valid && !m_ready, ##1 m_valid, "result dropped")

    // failed allocations grant nothing
    `PFA_ASSERT_IMP(a_fail_no_grant, aclk, aresetn, alloc_fail, no_grant, "grant on failure")

    // failures of allocation happen only with an empty list
    `PFA_ASSERT_IMP(a_fail_empty, aclk, aresetn, alloc_fail, list_empty, "failure with free frames")

    // an eviction is always a success with an empty list
    `PFA_ASSERT_IMP(a_evict_ok, aclk, aresetn, evicting, evict_ok, "bad eviction result")

endmodule

bind page_frame_allocator_with_victim pfa_checker u_pfa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire

// ----- tb/tb_page_frame_allocator_with_victim.sv -----
// ----------------------------------------------------------------------------
// tb_page_frame_allocator_with_victim
// Drives add, allocate, allocate pageable, free, set age and unknown-mode items into the
// frame allocator under several idle patterns and checks every result
// against a behavioral frame book kept inside a scoreboard class.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_page_frame_allocator_with_victim;
    import pfa_pkg::*;

    localparam int NFRAMES = 1024;
    localparam int QUIET_LIMIT = 20000;
    localparam int ITEMS_PER_PHASE = 139;

    class frame_book;
        logic [2:0]  kind_of [NFRAMES];
        bit          alloc_of [NFRAMES];
        bit          pgbl_of [NFRAMES];
        bit          queued [NFRAMES];
        logic [31:0] age_of [NFRAMES];
        logic [19:0] vpage_of [NFRAMES];
        logic [15:0] owner_of [NFRAMES];
        logic [9:0]  free_list [NFRAMES];
        int          head, tail, total;
        pfa_out_t    pending [$];
        int          errors;

        function new();
            for (int i = 0; i < NFRAMES; i++) begin
                kind_of[i] = '0; alloc_of[i] = 0; pgbl_of[i] = 0; queued[i] = 0;
                age_of[i] = '0; vpage_of[i] = '0; owner_of[i] = '0; free_list[i] = '0;
            end
            head = 0; tail = 0; total = 0; errors = 0;
        endfunction

        function void push_free(int f);
            free_list[tail] = f[9:0];
            tail = (tail + 1) % NFRAMES;
            queued[f] = 1;
            total++;
        endfunction

        // work out the result of one accepted item and update the book
        function void note(pfa_in_t it);
            pfa_out_t r;
            int f, g, best;
            bit found;
            r = '0;
            f = int'(it.frame);
            case (it.mode) inside
                MODE_ADD: begin
                    if (!queued[f]) begin
                        kind_of[f] = it.frame_kind;
                        alloc_of[f] = (it.frame_kind == KIND_ALLOCATED);
                        pgbl_of[f] = 0;
                        age_of[f] = '0; vpage_of[f] = '0; owner_of[f] = '0;
                        if (it.frame_kind == KIND_AVAILABLE) push_free(f);
                    end
                end
                MODE_ALLOC, MODE_ALLOC_PG: begin
                    if (total > 0) begin
                        g = int'(free_list[head]);
                        head = (head + 1) % NFRAMES;
                        queued[g] = 0;
                        total--;
                        alloc_of[g] = 1;
                        if (it.mode == MODE_ALLOC_PG) begin
                            pgbl_of[g] = 1;
                            vpage_of[g] = it.vpage;
                            owner_of[g] = it.owner_tag;
                        end
                        r.frame_out = g[9:0];
                    end else if (it.mode == MODE_ALLOC) begin
                        r.status = STATUS_NO_FREE;
                    end else begin
                        found = 0; best = 0;
                        for (int i = 0; i < NFRAMES; i++)
                            if (alloc_of[i] && pgbl_of[i] &&
                                (!found || age_of[i] < age_of[best])) begin
                                best = i;
                                found = 1;
                            end
                        if (!found) begin
                            r.status = STATUS_NO_VICTIM;
                        end else begin
                            r.evicted = 1'b1;
                            r.evicted_vpage = vpage_of[best];
                            r.evicted_owner = owner_of[best];
                            vpage_of[best] = it.vpage;
                            owner_of[best] = it.owner_tag;
                            r.frame_out = best[9:0];
                        end
                    end
                end
                MODE_FREE: begin
                    if (!alloc_of[f]) begin
                        r.status = STATUS_NOT_ALLOC;
                    end else begin
                        alloc_of[f] = 0;
                        pgbl_of[f] = 0;
                        push_free(f);
                    end
                end
                MODE_SET_AGE: age_of[f] = it.age;
                default: ;
            endcase
            r.free_count = total[10:0];
            pending.push_back(r);
        endfunction

        task report(string what);
            $display("error: %s", what);
            errors++;
        endtask

        task check(pfa_out_t got);
            pfa_out_t exp_r;
            if (pending.size() == 0) begin
                report("result with no item waiting");
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status)
                report($sformatf("status %0d want %0d", got.status, exp_r.status));
            if (got.frame_out !== exp_r.frame_out)
                report($sformatf("frame_out %0d want %0d", got.frame_out, exp_r.frame_out));
            if (got.evicted !== exp_r.evicted)
                report($sformatf("evicted %0b want %0b", got.evicted, exp_r.evicted));
            if (got.evicted_vpage !== exp_r.evicted_vpage)
                report($sformatf("evicted_vpage %h want %h", got.evicted_vpage,
                                 exp_r.evicted_vpage));
            if (got.evicted_owner !== exp_r.evicted_owner)
                report($sformatf("evicted_owner %h want %h", got.evicted_owner,
                                 exp_r.evicted_owner));
            if (got.free_count !== exp_r.free_count)
                report($sformatf("free_count %0d want %0d", got.free_count, exp_r.free_count));
        endtask
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    pfa_in_t  s_item;
    logic     m_valid;
    logic     m_ready;
    pfa_out_t m_item;

    int sidle = 0;
    int ridle = 0;
    int quiet = 0;
    frame_book book = new();

    page_frame_allocator_with_victim dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(negedge aclk) m_ready = ($urandom_range(99) >= ridle);

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) book.check(m_item);
    end

    // ends the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("page_frame_allocator_with_victim: mismatch");
                $finish;
            end
        end
    end

    task send(input pfa_in_t it);
        if (sidle > 0 && $urandom_range(99) < sidle) begin
            s_valid = 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < sidle) @(negedge aclk);
        end
        s_item = it;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        book.note(it);
        @(negedge aclk);
    endtask

    task send_op(input logic [2:0] mode, input int frame, input logic [2:0] kind,
                 input logic [19:0] vp, input logic [15:0] own, input logic [31:0] age);
        pfa_in_t it;
        it.mode = mode; it.frame = frame[9:0]; it.frame_kind = kind;
        it.vpage = vp; it.owner_tag = own; it.age = age;
        send(it);
    endtask

    function pfa_in_t rand_item();
        pfa_in_t it;
        int r;
        it.vpage = 20'($urandom);
        it.owner_tag = 16'($urandom);
        // small ages make ties among victims likely
        it.age = $urandom_range(1) ? $urandom : $urandom_range(3);
        it.frame = 10'(($urandom_range(3) == 0) ? $urandom_range(1023) : $urandom_range(23));
        r = $urandom_range(9);
        if (r < 5)      it.frame_kind = KIND_AVAILABLE;
        else if (r < 7) it.frame_kind = KIND_ALLOCATED;
        else            it.frame_kind = 3'($urandom_range(7));
        r = $urandom_range(99);
        if (r < 18)      it.mode = MODE_ADD;
        else if (r < 38) it.mode = MODE_ALLOC;
        else if (r < 60) it.mode = MODE_ALLOC_PG;
        else if (r < 82) it.mode = MODE_FREE;
        else if (r < 94) it.mode = MODE_SET_AGE;
        else             it.mode = 3'($urandom_range(7, 5));
        return it;
    endfunction

    initial begin
        int sid [4];
        int rid [4];
        sid = '{0, 75, 0, 34};
        rid = '{0, 0, 75, 34};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        m_ready = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part
        send_op(MODE_ALLOC_PG, 0, 0, '1, '1, '0);           // no victim at all
        send_op(MODE_ALLOC, 0, 0, '0, '0, '0);              // empty list
        send_op(MODE_ADD, 0, KIND_AVAILABLE, '1, '1, '1);
        send_op(MODE_ADD, 1023, KIND_AVAILABLE, '0, '0, '0);
        send_op(MODE_ADD, 0, KIND_ALLOCATED, '0, '0, '0);   // already queued, ignored
        send_op(MODE_ADD, 2, KIND_ALLOCATED, '0, '0, '0);
        send_op(MODE_ADD, 3, 3'd6, '0, '0, '0);
        send_op(MODE_ADD, 4, 3'd7, '0, '0, '0);
        send_op(MODE_ADD, 5, 3'd2, '0, '0, '0);
        send_op(MODE_ADD, 6, 3'd5, '0, '0, '0);
        send_op(MODE_FREE, 3, 0, '0, '0, '0);               // not allocated
        send_op(MODE_FREE, 2, 0, '0, '0, '0);
        send_op(MODE_ALLOC_PG, 0, 0, 20'hfffff, 16'hffff, '0);
        send_op(MODE_ALLOC_PG, 0, 0, 20'h12345, 16'h0001, '0);
        send_op(MODE_ALLOC, 0, 0, '0, '0, '0);
        send_op(MODE_SET_AGE, 0, 0, '0, '0, 32'hffffffff);
        send_op(MODE_SET_AGE, 1023, 0, '0, '0, 32'h0);
        send_op(MODE_ALLOC_PG, 0, 0, 20'h00001, 16'h8000, '0); // steals 1023
        send_op(MODE_SET_AGE, 1023, 0, '0, '0, 32'hffffffff);
        send_op(MODE_ALLOC_PG, 0, 0, 20'h00002, 16'h4000, '0); // tie, lowest index
        send_op(3'd5, 1023, 3'd7, '1, '1, '1);
        send_op(3'd6, 0, 0, '0, '0, '0);
        send_op(3'd7, 0, 0, '0, '0, '0);
        send_op(MODE_FREE, 0, 0, '0, '0, '0);

        for (int p = 0; p < 4; p++) begin
            sidle = sid[p];
            ridle = rid[p];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send(rand_item());
        end
        s_valid = 1'b0;

        while (book.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (book.errors == 0) begin
            $display("page_frame_allocator_with_victim: match");
        end else begin
            $display("page_frame_allocator_with_victim: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- page_frame_allocator_with_victim.f -----
+incdir+hdl
hdl/pfa_pkg.sv
hdl/pfa_store.sv
hdl/pfa_victim.sv
hdl/page_frame_allocator_with_victim.sv
hdl/pfa_checker.sv
tb/tb_page_frame_allocator_with_victim.sv
